### rtl/lldp_pkg.sv
// ----------------------------------------------------------------------------
// lldp_pkg
// Shared types and constants of the LLDP TLV frame parser.
// ----------------------------------------------------------------------------
package lldp_pkg;

    localparam int DEF_TEXT_BUFFER = 200;
    localparam int DEF_MAX_FRAME   = 2048;
    localparam int DEF_OP_DEPTH    = 4;
    localparam int DEF_RES_DEPTH   = 4;

    // frame byte counts cover frame lengths up to 8191
    localparam int REM_W = 13;

    localparam logic [15:0] LLDP_TYPE = 16'h88CC;
    localparam logic [15:0] VLAN_TYPE = 16'h8100;
    localparam logic [4:0]  HDR_PLAIN = 5'd14;
    localparam logic [4:0]  HDR_VLAN  = 5'd18;

    localparam logic [6:0] TLV_END     = 7'd0;
    localparam logic [6:0] TLV_CHASSIS = 7'd1;
    localparam logic [6:0] TLV_PORT    = 7'd2;
    localparam logic [6:0] TLV_TTL     = 7'd3;
    localparam logic [6:0] TLV_PDESC   = 7'd4;
    localparam logic [6:0] TLV_SYSNAME = 7'd5;

    localparam logic [7:0] SUB_CHASSIS_MAC = 8'd4;
    localparam logic [7:0] SUB_PORT_MAC    = 8'd3;
    localparam logic [8:0] MAC_TLV_LEN     = 9'd7;

    localparam logic [1:0] KIND_BEGIN   = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [11:0] frame_length;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  field;
        logic        is_mac;
        logic [7:0]  value_byte;
        logic [15:0] ttl_value;
        logic        ttl_seen;
        logic        run_end;
    } result_t;

    // one unit of work for the TLV walker
    typedef struct packed {
        logic             reset;
        logic             summary;
        logic             step_end;
        logic [7:0]       data;
        logic [REM_W-1:0] rem;
    } op_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_HEAD,
        F_VLAN,
        F_WALK,
        F_REPLAY,
        F_SUMMARY
    } front_state_t;

    typedef enum logic [1:0] {
        W_T0,
        W_T1,
        W_VAL,
        W_DONE
    } walk_state_t;

endpackage

### rtl/lldp_fifo.sv
// ----------------------------------------------------------------------------
// lldp_fifo
// Small first-word-fall-through queue built from registers.
// ----------------------------------------------------------------------------
module lldp_fifo
    import lldp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEF_OP_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (PW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push & ~do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop & ~do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

endmodule

### rtl/lldp_front.sv
// ----------------------------------------------------------------------------
// lldp_front
// Frame tracking: header collection, type check, VLAN skip, header replay.
// ----------------------------------------------------------------------------
module lldp_front
    import lldp_pkg::*;
#(
    parameter int MAX_FRAME = DEF_MAX_FRAME
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t item,
    output logic  full,
    output logic  op_valid,
    output op_t   op,
    input  logic  q_full
);

    localparam logic [REM_W-1:0] MAXF = REM_W'(MAX_FRAME);

    front_state_t     state_reg, state_next, cur_state;
    logic [4:0]       pos_reg, pos_next, cur_pos, pos_inc;
    logic [REM_W-1:0] remaining_reg, remaining_next, cur_rem;
    logic [3:0]       idx_reg, idx_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0] total_reg, total_next, total;
    logic             rlast_reg, rlast_next;
    logic             pend_reg, pend_next;
    logic [7:0]       hdr_reg [14];

    logic             acc, is_first, live, has_byte, last;
    logic [REM_W-1:0] flen, sat_len;
    logic             hdr_done, to_vlan, to_lldp, to_replay, walk_byte;
    logic [15:0]      eth_type;

    assign full     = q_full | (state_reg == F_REPLAY) | (state_reg == F_SUMMARY);
    assign acc      = push & ~full;
    assign is_first = acc & item.first_byte;
    assign last     = item.last_byte;
    assign flen     = {1'b0, item.frame_length};
    assign sat_len  = (flen > MAXF) ? MAXF : flen;

    assign cur_state = is_first ? ((sat_len >= REM_W'(HDR_PLAIN)) ? F_HEAD : F_WALK)
                                : state_reg;
    assign cur_rem   = is_first ? sat_len : remaining_reg;
    assign cur_pos   = is_first ? 5'd0 : pos_reg;
    assign pos_inc   = cur_pos + 5'd1;

    assign live      = acc & (is_first | (state_reg != F_IDLE));
    assign has_byte  = live & (cur_rem != '0);
    assign walk_byte = has_byte & (cur_state == F_WALK);

    // byte 13 is on the input now, byte 12 is already stored
    assign eth_type  = {hdr_reg[12], item.data_byte};
    assign hdr_done  = has_byte & (cur_state == F_HEAD) & ((pos_inc >= HDR_PLAIN) | last);
    assign total     = REM_W'(pos_inc) + (last ? '0 : cur_rem - 1'b1);
    assign to_vlan   = hdr_done & (pos_inc == HDR_PLAIN) & (eth_type == VLAN_TYPE)
                       & (total >= REM_W'(HDR_VLAN));
    assign to_lldp   = hdr_done & (pos_inc == HDR_PLAIN) & (eth_type == LLDP_TYPE);
    assign to_replay = hdr_done & ~to_vlan & ~to_lldp;

    // next state
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        remaining_next = remaining_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        rlast_next     = rlast_reg;
        case (state_reg)
            F_REPLAY:
            begin
                if (!q_full)
                begin
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg + 4'd1 == cnt_reg)
                    begin
                        state_next = rlast_reg ? F_SUMMARY : F_WALK;
                    end
                end
            end
            F_SUMMARY:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                if (live)
                begin
                    state_next     = cur_state;
                    pos_next       = cur_pos;
                    remaining_next = cur_rem;
                    if (has_byte)
                    begin
                        remaining_next = cur_rem - 1'b1;
                        case (cur_state)
                            F_HEAD:
                            begin
                                pos_next = pos_inc;
                                if (to_vlan)
                                begin
                                    state_next = F_VLAN;
                                end
                                else if (to_lldp)
                                begin
                                    state_next = F_WALK;
                                end
                                else if (to_replay)
                                begin
                                    state_next = F_REPLAY;
                                    idx_next   = 4'd0;
                                    cnt_next   = pos_inc[3:0];
                                    total_next = total;
                                    rlast_next = last;
                                end
                            end
                            F_VLAN:
                            begin
                                pos_next = pos_inc;
                                if (pos_inc >= HDR_VLAN)
                                begin
                                    state_next = F_WALK;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    if (last & ~to_replay)
                    begin
                        state_next = walk_byte ? F_SUMMARY : F_IDLE;
                    end
                end
            end
        endcase
    end

    // outputs toward the walker queue
    always_comb
    begin
        op_valid = 1'b0;
        op       = '0;
        case (state_reg)
            F_REPLAY:
            begin
                op_valid    = ~q_full;
                op.reset    = pend_reg;
                op.data     = hdr_reg[idx_reg];
                op.rem      = total_reg - REM_W'(idx_reg);
                op.step_end = (idx_reg + 4'd1 == cnt_reg) & ~rlast_reg;
            end
            F_SUMMARY:
            begin
                op_valid    = ~q_full;
                op.reset    = pend_reg;
                op.summary  = 1'b1;
                op.step_end = 1'b1;
            end
            default:
            begin
                if (walk_byte)
                begin
                    op_valid    = 1'b1;
                    op.reset    = pend_reg | is_first;
                    op.data     = item.data_byte;
                    op.rem      = cur_rem;
                    op.step_end = ~last;
                end
                else if (live & last & ~to_replay)
                begin
                    op_valid    = 1'b1;
                    op.reset    = pend_reg | is_first;
                    op.summary  = 1'b1;
                    op.step_end = 1'b1;
                end
            end
        endcase
    end

    // a frame start travels with the first word sent for that frame
    always_comb
    begin
        pend_next = pend_reg;
        if (op_valid)
        begin
            pend_next = 1'b0;
        end
        else if (is_first)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            pos_reg       <= '0;
            remaining_reg <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            rlast_reg     <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            remaining_reg <= remaining_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            rlast_reg     <= rlast_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (has_byte && cur_state == F_HEAD)
        begin
            hdr_reg[cur_pos[3:0]] <= item.data_byte;
        end
    end

endmodule

### rtl/lldp_back.sv
// ----------------------------------------------------------------------------
// lldp_back
// TLV walker: decodes TLV headers and values and builds result words.
// ----------------------------------------------------------------------------
module lldp_back
    import lldp_pkg::*;
#(
    parameter int TEXT_BUFFER = DEF_TEXT_BUFFER
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  op_t     op,
    input  logic    op_empty,
    output logic    op_pop,
    output logic    res_push,
    output result_t res,
    input  logic    res_full
);

    walk_state_t wst_reg, wst_next, c_wst;
    logic [6:0]  kind_reg, n_kind, c_kind;
    logic [8:0]  len_reg, n_len, c_len;
    logic [8:0]  off_reg, n_off, c_off;
    logic        mac_reg, n_mac, c_mac;
    logic [7:0]  tc_reg, n_tc, c_tc;
    logic        ts_reg, n_ts, c_ts;
    logic [15:0] ttl_reg, n_ttl, c_ttl;
    logic        ttlv_reg, n_ttlv, c_ttlv;

    result_t     held_reg, held_next, r;
    logic        held_v_reg, held_v_next;
    logic        close_reg, close_next;
    logic        rv, do_text;
    logic [1:0]  txt_fld;

    logic [8:0]  len_full;
    logic        t1_stop, mac_hit, is_id, is_text;
    logic [9:0]  off_inc;

    // a frame start clears the walk before this word is applied
    assign c_wst  = op.reset ? W_T0  : wst_reg;
    assign c_kind = op.reset ? '0    : kind_reg;
    assign c_len  = op.reset ? '0    : len_reg;
    assign c_off  = op.reset ? '0    : off_reg;
    assign c_mac  = op.reset ? 1'b0  : mac_reg;
    assign c_tc   = op.reset ? '0    : tc_reg;
    assign c_ts   = op.reset ? 1'b0  : ts_reg;
    assign c_ttl  = op.reset ? '0    : ttl_reg;
    assign c_ttlv = op.reset ? 1'b0  : ttlv_reg;

    assign op_pop   = ~op_empty & ~close_reg & ~res_full;
    assign len_full = {c_len[8], op.data};
    assign t1_stop  = (REM_W'({1'b0, len_full}) + 1'b1 > op.rem) | (c_kind == TLV_END);
    assign off_inc  = {1'b0, c_off} + 10'd1;
    assign is_id    = (c_kind == TLV_CHASSIS) | (c_kind == TLV_PORT);
    assign is_text  = (c_kind == TLV_PDESC) | (c_kind == TLV_SYSNAME);
    assign mac_hit  = (((c_kind == TLV_CHASSIS) & (op.data == SUB_CHASSIS_MAC))
                       | ((c_kind == TLV_PORT) & (op.data == SUB_PORT_MAC)))
                      & (c_len == MAC_TLV_LEN);

    // walker phase
    always_comb
    begin
        wst_next = wst_reg;
        if (op_pop)
        begin
            wst_next = c_wst;
            if (!op.summary)
            begin
                case (c_wst)
                    W_T0:
                    begin
                        wst_next = (op.rem < REM_W'(2)) ? W_DONE : W_T1;
                    end
                    W_T1:
                    begin
                        if (t1_stop)
                        begin
                            wst_next = W_DONE;
                        end
                        else
                        begin
                            wst_next = (len_full == '0) ? W_T0 : W_VAL;
                        end
                    end
                    W_VAL:
                    begin
                        wst_next = (off_inc >= {1'b0, c_len}) ? W_T0 : W_VAL;
                    end
                    default:
                    begin
                        wst_next = W_DONE;
                    end
                endcase
            end
        end
    end

    // walker data and the result of this word
    always_comb
    begin
        n_kind  = c_kind;
        n_len   = c_len;
        n_off   = c_off;
        n_mac   = c_mac;
        n_tc    = c_tc;
        n_ts    = c_ts;
        n_ttl   = c_ttl;
        n_ttlv  = c_ttlv;
        rv      = 1'b0;
        r       = '0;
        do_text = 1'b0;
        txt_fld = 2'd0;
        if (op.summary)
        begin
            rv          = 1'b1;
            r.kind      = KIND_SUMMARY;
            r.ttl_value = c_ttl;
            r.ttl_seen  = c_ttlv;
        end
        else
        begin
            case (c_wst)
                W_T0:
                begin
                    if (op.rem >= REM_W'(2))
                    begin
                        n_kind = op.data[7:1];
                        n_len  = {op.data[0], 8'h00};
                    end
                end
                W_T1:
                begin
                    n_len = len_full;
                    if (!t1_stop)
                    begin
                        n_off = '0;
                        if (is_text && len_full != '0)
                        begin
                            n_tc    = '0;
                            n_ts    = 1'b0;
                            rv      = 1'b1;
                            r.kind  = KIND_BEGIN;
                            r.field = 2'(c_kind - TLV_PDESC) + 2'd2;
                        end
                    end
                end
                W_VAL:
                begin
                    n_off = off_inc[8:0];
                    if (is_id)
                    begin
                        txt_fld = 2'(c_kind - TLV_CHASSIS);
                        if (c_off == '0)
                        begin
                            n_mac    = mac_hit;
                            n_tc     = '0;
                            n_ts     = 1'b0;
                            rv       = 1'b1;
                            r.kind   = KIND_BEGIN;
                            r.field  = txt_fld;
                            r.is_mac = mac_hit;
                        end
                        else if (c_mac)
                        begin
                            rv           = 1'b1;
                            r.kind       = KIND_BYTE;
                            r.field      = txt_fld;
                            r.is_mac     = 1'b1;
                            r.value_byte = op.data;
                        end
                        else
                        begin
                            do_text = 1'b1;
                        end
                    end
                    else if (c_kind == TLV_TTL && c_len >= 9'd2)
                    begin
                        if (c_off == 9'd0)
                        begin
                            n_tc = op.data;
                        end
                        else if (c_off == 9'd1)
                        begin
                            n_ttl  = {c_tc, op.data};
                            n_ttlv = 1'b1;
                        end
                    end
                    else if (is_text)
                    begin
                        txt_fld = 2'(c_kind - TLV_PDESC) + 2'd2;
                        do_text = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            // text capture: stop at NUL or at the buffer limit
            if (do_text && !c_ts)
            begin
                if (op.data == 8'd0)
                begin
                    n_ts = 1'b1;
                end
                else if ({1'b0, c_tc} + 9'd1 < 9'(TEXT_BUFFER))
                begin
                    rv           = 1'b1;
                    r.kind       = KIND_BYTE;
                    r.field      = txt_fld;
                    r.value_byte = op.data;
                    n_tc         = c_tc + 8'd1;
                end
                else
                begin
                    n_ts = 1'b1;
                end
            end
        end
    end

    // hold one result back so the last one of a step can carry run_end
    always_comb
    begin
        res_push    = 1'b0;
        res         = held_reg;
        held_next   = held_reg;
        held_v_next = held_v_reg;
        close_next  = close_reg;
        if (close_reg)
        begin
            if (!res_full)
            begin
                res_push    = 1'b1;
                res.run_end = 1'b1;
                held_v_next = 1'b0;
                close_next  = 1'b0;
            end
        end
        else if (op_pop)
        begin
            if (rv)
            begin
                if (held_v_reg)
                begin
                    res_push    = 1'b1;
                    res.run_end = 1'b0;
                    held_next   = r;
                    close_next  = op.step_end;
                end
                else if (op.step_end)
                begin
                    res_push    = 1'b1;
                    res         = r;
                    res.run_end = 1'b1;
                end
                else
                begin
                    held_next   = r;
                    held_v_next = 1'b1;
                end
            end
            else if (op.step_end && held_v_reg)
            begin
                res_push    = 1'b1;
                res.run_end = 1'b1;
                held_v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wst_reg    <= W_T0;
            kind_reg   <= '0;
            len_reg    <= '0;
            off_reg    <= '0;
            mac_reg    <= 1'b0;
            tc_reg     <= '0;
            ts_reg     <= 1'b0;
            ttl_reg    <= '0;
            ttlv_reg   <= 1'b0;
            held_v_reg <= 1'b0;
            close_reg  <= 1'b0;
        end
        else
        begin
            wst_reg    <= wst_next;
            held_v_reg <= held_v_next;
            close_reg  <= close_next;
            if (op_pop)
            begin
                kind_reg <= n_kind;
                len_reg  <= n_len;
                off_reg  <= n_off;
                mac_reg  <= n_mac;
                tc_reg   <= n_tc;
                ts_reg   <= n_ts;
                ttl_reg  <= n_ttl;
                ttlv_reg <= n_ttlv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

### rtl/lldp_tlv_frame_parser.sv
// ----------------------------------------------------------------------------
// lldp_tlv_frame_parser
// LLDP frame parser: strips the Ethernet header, walks the TLVs and reports
// chassis ID, port ID, port description, system name and TTL per frame.
// ----------------------------------------------------------------------------
//
//   channel  handshake         payload   direction
//   -------  ----------------  --------  ---------
//   input    push / full       item      into block, one frame byte per word
//   result   pop / empty       result    out of block, oldest result first
//
// One frame byte is taken per cycle while full is low. The front tracks the
// frame and strips the header; the walker behind a 4-word queue decodes
// TLVs, one byte a cycle unless the result queue is full or a step closes.
// A non-LLDP type, a VLAN type too short for its tag or a frame ending
// before its 14th header byte replays the stored header bytes through the
// walker while full is high, as it also is for the summary after a last
// walk byte. Two results held at a step's end both go out before new words.
// Reset (rst_n low) drops any open frame and empties both queues.
// ----------------------------------------------------------------------------
module lldp_tlv_frame_parser
    import lldp_pkg::*;
#(
    parameter int TEXT_BUFFER = DEF_TEXT_BUFFER,
    parameter int MAX_FRAME   = DEF_MAX_FRAME,
    parameter int OP_DEPTH    = DEF_OP_DEPTH,
    parameter int RES_DEPTH   = DEF_RES_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   item,
    output logic    full,
    input  logic    pop,
    output result_t result,
    output logic    empty
);

    op_t     op_in, op_out;
    logic    op_valid, q_full, op_empty, op_pop;
    result_t res;
    logic    res_push, res_full;

    // front: frame tracking, header strip and replay
    lldp_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .op_valid (op_valid),
        .op       (op_in),
        .q_full   (q_full)
    );

    // decouple frame tracking from the walker
    lldp_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (OP_DEPTH)
    ) u_op_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_valid),
        .wdata (op_in),
        .full  (q_full),
        .pop   (op_pop),
        .rdata (op_out),
        .empty (op_empty)
    );

    // back: TLV walker
    lldp_back #(
        .TEXT_BUFFER (TEXT_BUFFER)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op_out),
        .op_empty (op_empty),
        .op_pop   (op_pop),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full)
    );

    // result queue: hold results while the consumer stalls
    lldp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

### rtl/lldp_checker.sv
// ----------------------------------------------------------------------------
// lldp_checker
// Port-level checks of the parser's result stream.
// ----------------------------------------------------------------------------
module lldp_checker
    import lldp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    pop,
    input result_t result,
    input logic    empty
);

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before pop");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.kind != 2'd3))
        else $error("result kind out of range");

    a_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_SUMMARY) |->
        (result.field == 2'd0 && !result.is_mac && result.value_byte == 8'd0
         && result.run_end))
        else $error("malformed summary word");

    a_field: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_SUMMARY) |->
        (result.ttl_value == 16'd0 && !result.ttl_seen))
        else $error("TTL data outside a summary");

    a_begin: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_BEGIN) |-> (result.value_byte == 8'd0))
        else $error("field begin carries a value byte");

endmodule

bind lldp_tlv_frame_parser lldp_checker u_lldp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .result (result),
    .empty  (empty)
);

### tb/sv/lldp_tlv_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lldp_tlv_frame_checker
// Watches the item and result channels of the LLDP TLV frame parser, decodes
// each accepted frame byte on its own and compares every result word in order.
// ----------------------------------------------------------------------------
module lldp_tlv_frame_checker
    import lldp_pkg::*;
#(
    parameter int TEXT_BUFFER = DEF_TEXT_BUFFER,
    parameter int MAX_FRAME   = DEF_MAX_FRAME
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   item,
    input  logic    full,
    input  logic    pop,
    input  result_t result,
    input  logic    empty,
    output int      fail_count,
    output int      pending
);

    typedef enum int {
        P_IDLE,
        P_HEAD,
        P_VLAN,
        P_T0,
        P_T1,
        P_VAL,
        P_DONE
    } parse_phase_t;

    parse_phase_t phase;
    int           hdr_count;
    int           left;
    logic [7:0]   hdr [14];
    int           cur_type;
    int           cur_len;
    int           val_idx;
    logic         mac_field;
    int           txt_count;
    logic         txt_stop;
    logic [15:0]  ttl_reg;
    logic         ttl_ok;

    result_t      step_words[$];
    result_t      expected_words[$];

    function automatic result_t mk(logic [1:0] k, logic [1:0] f, logic m,
                                   logic [7:0] v, logic [15:0] t, logic s);
        result_t r;
        r.kind       = k;
        r.field      = f;
        r.is_mac     = m;
        r.value_byte = v;
        r.ttl_value  = t;
        r.ttl_seen   = s;
        r.run_end    = 1'b0;
        return r;
    endfunction

    task automatic capture_text(logic [7:0] b, logic [1:0] f);
        if (txt_stop)
            return;
        if (b == 8'd0)
            txt_stop = 1'b1;
        else if (txt_count + 1 < TEXT_BUFFER)
        begin
            step_words.push_back(mk(KIND_BYTE, f, 1'b0, b, 16'd0, 1'b0));
            txt_count++;
        end
        else
            txt_stop = 1'b1;
    endtask

    task automatic walk_tlv(logic [7:0] b, int rem);
        int k;
        k = cur_type;
        case (phase)
            P_T0:
            begin
                if (rem < 2)
                begin
                    phase = P_DONE;
                    return;
                end
                cur_type = b[7:1];
                cur_len  = int'(b[0]) << 8;
                phase    = P_T1;
            end
            P_T1:
            begin
                cur_len = cur_len | b;
                if (cur_len + 1 > rem || k == TLV_END)
                begin
                    phase = P_DONE;
                    return;
                end
                val_idx = 0;
                if ((k == TLV_PDESC || k == TLV_SYSNAME) && cur_len >= 1)
                begin
                    txt_count = 0;
                    txt_stop  = 1'b0;
                    step_words.push_back(mk(KIND_BEGIN, 2'(k - 2), 1'b0, 8'd0, 16'd0, 1'b0));
                end
                phase = (cur_len == 0) ? P_T0 : P_VAL;
            end
            P_VAL:
            begin
                if (k == TLV_CHASSIS || k == TLV_PORT)
                begin
                    if (val_idx == 0)
                    begin
                        mac_field = (b == (k == TLV_CHASSIS ? SUB_CHASSIS_MAC : SUB_PORT_MAC))
                                    && cur_len == MAC_TLV_LEN;
                        txt_count = 0;
                        txt_stop  = 1'b0;
                        step_words.push_back(mk(KIND_BEGIN, 2'(k - 1), mac_field, 8'd0,
                                                16'd0, 1'b0));
                    end
                    else if (mac_field)
                        step_words.push_back(mk(KIND_BYTE, 2'(k - 1), 1'b1, b, 16'd0, 1'b0));
                    else
                        capture_text(b, 2'(k - 1));
                end
                else if (k == TLV_TTL && cur_len >= 2)
                begin
                    // hold the high byte in the text counter until the low byte
                    if (val_idx == 0)
                        txt_count = b;
                    else if (val_idx == 1)
                    begin
                        ttl_reg = {txt_count[7:0], b};
                        ttl_ok  = 1'b1;
                    end
                end
                else if (k == TLV_PDESC || k == TLV_SYSNAME)
                    capture_text(b, 2'(k - 2));
                val_idx++;
                if (val_idx >= cur_len)
                    phase = P_T0;
            end
            default: ;
        endcase
    endtask

    task automatic judge_header(logic last);
        int total;
        total = hdr_count + (last ? 0 : left);
        if (hdr_count == HDR_PLAIN)
        begin
            if ({hdr[12], hdr[13]} == VLAN_TYPE && total >= HDR_VLAN)
            begin
                phase = P_VLAN;
                return;
            end
            if ({hdr[12], hdr[13]} == LLDP_TYPE)
            begin
                phase = P_T0;
                return;
            end
        end
        // replay what was collected as TLVs
        phase = P_T0;
        for (int i = 0; i < hdr_count && i < HDR_PLAIN; i++)
            walk_tlv(hdr[i], total - i);
    endtask

    task automatic predict_byte(item_t it);
        int n;
        int rem;
        step_words.delete();
        if (it.first_byte)
        begin
            n = (it.frame_length > MAX_FRAME) ? MAX_FRAME : it.frame_length;
            left      = n;
            hdr_count = 0;
            cur_type  = 0;
            cur_len   = 0;
            val_idx   = 0;
            mac_field = 1'b0;
            txt_count = 0;
            txt_stop  = 1'b0;
            ttl_reg   = 16'd0;
            ttl_ok    = 1'b0;
            phase     = (n >= HDR_PLAIN) ? P_HEAD : P_T0;
        end
        else if (phase == P_IDLE)
            return;
        if (left > 0)
        begin
            rem = left;
            left--;
            if (phase == P_HEAD)
            begin
                if (hdr_count < HDR_PLAIN)
                    hdr[hdr_count] = it.data_byte;
                hdr_count++;
                if (hdr_count >= HDR_PLAIN || it.last_byte)
                    judge_header(it.last_byte);
            end
            else if (phase == P_VLAN)
            begin
                hdr_count++;
                if (hdr_count >= HDR_VLAN)
                    phase = P_T0;
            end
            else
                walk_tlv(it.data_byte, rem);
        end
        if (it.last_byte)
        begin
            step_words.push_back(mk(KIND_SUMMARY, 2'd0, 1'b0, 8'd0, ttl_reg, ttl_ok));
            phase = P_IDLE;
        end
        if (step_words.size() > 16)
            step_words = step_words[0:15];
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].run_end = 1'b1;
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            phase      = P_IDLE;
            hdr_count  = 0;
            left       = 0;
            cur_type   = 0;
            cur_len    = 0;
            val_idx    = 0;
            mac_field  = 1'b0;
            txt_count  = 0;
            txt_stop   = 1'b0;
            ttl_reg    = 16'd0;
            ttl_ok     = 1'b0;
            fail_count = 0;
            pending    = 0;
            expected_words.delete();
        end
        else
        begin
            // check the popped word before queuing this edge's predictions
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result word %p", $realtime, result);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (result !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: result word expected %p got %p",
                                     $realtime, want, result);
                    end
                end
            end
            if (push && !full)
                predict_byte(item);
            pending = expected_words.size();
        end
    end

endmodule

### tb/sv/tb_lldp_tlv_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lldp_tlv_frame_parser
// Feeds directed and random LLDP frames, byte by byte, with random gaps on
// both channels; the checker beside the parser predicts and compares.
// ----------------------------------------------------------------------------
module tb_lldp_tlv_frame_parser;
    import lldp_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    push;
    item_t   item;
    logic    full;
    logic    pop;
    result_t result;
    logic    empty;
    int      fail_count;
    int      pending;

    // byte image of the frame being built
    logic [7:0] frame_bytes[$];

    lldp_tlv_frame_parser DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .pop    (pop),
        .result (result),
        .empty  (empty)
    );

    lldp_tlv_frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .pop        (pop),
        .result     (result),
        .empty      (empty),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: stall pop at random, with calm stretches of steady pop
    initial
    begin
        int n;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pop <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
            n = gap_len();
            if (n > 0)
            begin
                pop <= 1'b0;
                repeat (n) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    // send one word; hold push until the parser takes it
    task automatic send_word(logic [7:0] b, logic f, logic l, logic [11:0] len, logic gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
        push              <= 1'b1;
        item.data_byte    <= b;
        item.first_byte   <= f;
        item.last_byte    <= l;
        item.frame_length <= len;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // send the built frame; declared length and the real end may differ
    task automatic send_frame(int declared, int stop_at, logic gaps);
        for (int i = 0; i < stop_at; i++)
            send_word(frame_bytes[i], i == 0, i == stop_at - 1,
                      (i == 0) ? 12'(declared) : 12'($urandom), gaps);
    endtask

    task automatic add_tlv(int t, int len, logic [7:0] body[$]);
        frame_bytes.push_back({7'(t), 1'(len >> 8)});
        frame_bytes.push_back(8'(len));
        for (int i = 0; i < len; i++)
            frame_bytes.push_back(i < body.size() ? body[i] : 8'($urandom));
    endtask

    task automatic add_header(int kind);
        for (int i = 0; i < 12; i++)
            frame_bytes.push_back(8'($urandom));
        if (kind == 0)
        begin
            frame_bytes.push_back(LLDP_TYPE[15:8]);
            frame_bytes.push_back(LLDP_TYPE[7:0]);
        end
        else if (kind == 1)
        begin
            frame_bytes.push_back(VLAN_TYPE[15:8]);
            frame_bytes.push_back(VLAN_TYPE[7:0]);
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(LLDP_TYPE[15:8]);
            frame_bytes.push_back(LLDP_TYPE[7:0]);
        end
        else
        begin
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
        end
    endtask

    // random well-formed TLV body, with NULs, MAC subtypes and odd lengths
    task automatic add_random_tlvs(int count);
        logic [7:0] body[$];
        int         t;
        int         len;
        for (int j = 0; j < count; j++)
        begin
            body.delete();
            t = $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0: len = 7;
                1: len = 2;
                2: len = $urandom_range(0, 3);
                default: len = $urandom_range(1, 12);
            endcase
            if ($urandom_range(0, 1))
                body.push_back(t == TLV_CHASSIS ? SUB_CHASSIS_MAC : SUB_PORT_MAC);
            if ($urandom_range(0, 5) == 0)
                for (int i = 0; i < len; i++)
                    body.push_back(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
            add_tlv(t, len, body);
        end
        if ($urandom_range(0, 1))
            add_tlv(TLV_END, 0, body);
    endtask

    initial
    begin
        logic [7:0] body[$];
        int         sent;
        int         n;
        int         declared;
        int         stop_at;

        rst_n = 1'b0;
        push  = 1'b0;
        item  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray bytes with no open frame, marked last too
        send_word(8'hFF, 1'b0, 1'b1, 12'hFFF, 1'b0);
        send_word(8'h00, 1'b0, 1'b0, 12'h000, 1'b0);

        // directed: full LLDP frame with every field, MAC IDs and TTL
        frame_bytes.delete();
        add_header(0);
        body = '{SUB_CHASSIS_MAC, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04};
        add_tlv(TLV_CHASSIS, 7, body);
        body = '{SUB_PORT_MAC, 8'hAA, 8'h55, 8'h01, 8'h02, 8'h03, 8'h80};
        add_tlv(TLV_PORT, 7, body);
        body = '{8'hFF, 8'hFF};
        add_tlv(TLV_TTL, 2, body);
        body = '{8'h41, 8'h00, 8'h42};
        add_tlv(TLV_PDESC, 3, body);
        body = '{8'h7F, 8'h80};
        add_tlv(TLV_SYSNAME, 2, body);
        body.delete();
        add_tlv(TLV_PORT, 0, body);
        add_tlv(TLV_TTL, 1, body);
        add_tlv(TLV_END, 0, body);
        frame_bytes.push_back(8'hEE);   // past the declared length
        send_frame(frame_bytes.size() - 1, frame_bytes.size(), 1'b0);

        // directed: VLAN header, long system name that hits the text limit
        frame_bytes.delete();
        add_header(1);
        body.delete();
        for (int i = 0; i < 201; i++)
            body.push_back(8'($urandom_range(1, 255)));
        add_tlv(TLV_SYSNAME, 201, body);
        send_frame(frame_bytes.size(), frame_bytes.size(), 1'b0);

        // directed: other type replayed, short frames, zero and huge length
        frame_bytes.delete();
        add_header(2);
        send_frame(14, 14, 1'b0);
        frame_bytes = '{8'h02, 8'h03, 8'h03, 8'h01, 8'h02};
        send_frame(5, 5, 1'b0);
        send_frame(0, 3, 1'b0);
        frame_bytes.delete();
        add_header(1);
        send_frame(16, 16, 1'b0);       // VLAN type too short for the tag
        frame_bytes.delete();
        add_header(0);
        add_random_tlvs(3);
        send_frame(4095, 9, 1'b0);      // early end in header collection
        send_frame(4095, 20, 1'b0);     // early end in the walk

        // hold off until the parser has drained every result
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // random frames, mostly well formed
        sent = 0;
        while (sent < 60)
        begin
            frame_bytes.delete();
            n = $urandom_range(0, 9);
            if (n < 7)
            begin
                add_header(n < 4 ? 0 : (n < 6 ? 1 : 2));
                add_random_tlvs($urandom_range(1, 5));
            end
            else
                for (int i = $urandom_range(1, 24); i > 0; i--)
                    frame_bytes.push_back(8'($urandom));
            declared = frame_bytes.size();
            stop_at  = frame_bytes.size();
            case ($urandom_range(0, 9))
                0: declared = $urandom_range(0, declared);
                1: stop_at  = $urandom_range(1, stop_at);
                2: declared = declared + $urandom_range(1, 4);
                default: ;
            endcase
            if ($urandom_range(0, 15) == 0)
                send_word(8'($urandom), 1'b0, 1'($urandom), 12'($urandom), 1'b1);
            send_frame(declared, stop_at, $urandom_range(0, 3) != 0);
            sent += stop_at;
        end
        push <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (fail_count == 0)
            $display("lldp_tlv_frame_parser: match");
        else
            $display("lldp_tlv_frame_parser: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("lldp_tlv_frame_parser: mismatch");
        $finish;
    end

endmodule

### sim.f
rtl/lldp_pkg.sv
rtl/lldp_fifo.sv
rtl/lldp_front.sv
rtl/lldp_back.sv
rtl/lldp_tlv_frame_parser.sv
rtl/lldp_checker.sv
tb/sv/lldp_tlv_frame_checker.sv
tb/sv/tb_lldp_tlv_frame_parser.sv
